/* design/fcfl_pkg.sv */
// Shared constants and controller/datapath interface types for the chunk allocator.
`default_nettype none

package fcfl_pkg;

  localparam int NUM_CHUNKS_DEF = 64;
  localparam int CHUNK_BYTES_DEF = 16;

  localparam int OFFSET_W = 10;
  localparam int USED_W = 7;
  localparam int STATUS_W = 2;
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = STATUS_W;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FREE_NONE = 2'd2;

  typedef struct packed {
    logic init_wr;
    logic load;
    logic div_q;
    logic div_qq;
    logic div_idx;
    logic pop;
    logic push;
    logic reject;
  } dp_cmd_t;

  typedef struct packed {
    logic init_last;
    logic used_zero;
    logic used_full;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/fcfl_ctrl.sv */
// Controller state machine that sequences link-memory init, allocate and free requests.
`default_nettype none

module fcfl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              req_type,
  input  wire fcfl_pkg::dp_stat_t stat,
  output fcfl_pkg::dp_cmd_t      cmd
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ALLOC  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_QUO    = 3'd4;
  localparam logic [2:0] ST_IDX    = 3'd5;
  localparam logic [2:0] ST_PUSH   = 3'd6;
  localparam logic [2:0] ST_REJECT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (req_type == fcfl_pkg::REQ_ALLOC) begin
            state_next = stat.used_full ? ST_REJECT : ST_ALLOC;
          end else begin
            state_next = stat.used_zero ? ST_REJECT : ST_DIV;
          end
        end
      end
      ST_ALLOC: begin
        if (stat.out_free) begin
          cmd.pop = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_q = 1'b1;
        state_next = ST_QUO;
      end
      ST_QUO: begin
        cmd.div_qq = 1'b1;
        state_next = ST_IDX;
      end
      ST_IDX: begin
        cmd.div_idx = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (stat.out_free) begin
          cmd.reject = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/fcfl_datapath.sv */
// Datapath with the next-link memory, list head, used count, index divider and result register.
`default_nettype none

module fcfl_datapath #(
  parameter int NUM_CHUNKS = fcfl_pkg::NUM_CHUNKS_DEF,
  parameter int CHUNK_BYTES = fcfl_pkg::CHUNK_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire fcfl_pkg::dp_cmd_t                cmd,
  output fcfl_pkg::dp_stat_t                    stat,
  input  wire logic                             req_in,
  input  wire logic [fcfl_pkg::OFFSET_W-1:0]    offs_in,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [fcfl_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic [fcfl_pkg::M_TUSER_W-1:0]        m_tuser
);

  localparam int OW = fcfl_pkg::OFFSET_W;
  localparam int IW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int UW = $clog2(NUM_CHUNKS + 1);
  localparam int NW = UW;
  localparam int CBW = $clog2(CHUNK_BYTES + 1);
  localparam int L1 = $clog2(CHUNK_BYTES);
  localparam int S1 = OW + L1;
  localparam int M1 = (2 ** S1) / CHUNK_BYTES + 1;
  localparam int M1W = OW + 1;
  localparam int QW = (OW + 1 > L1) ? (OW + 1 - L1) : 1;
  localparam int L2 = $clog2(NUM_CHUNKS);
  localparam int S2 = QW + L2;
  localparam int M2 = (2 ** S2) / NUM_CHUNKS + 1;
  localparam int M2W = QW + 1;
  localparam int PADW = fcfl_pkg::M_TDATA_W - OW - fcfl_pkg::USED_W;

  logic [IW-1:0] link_mem [NUM_CHUNKS];
  logic [IW-1:0] rd_data;
  logic [IW-1:0] head;
  logic [UW-1:0] used;
  logic [IW-1:0] init_cnt;
  logic [IW-1:0] init_cnt_next;
  logic          req_reg;
  logic [OW-1:0] offs_reg;
  logic [QW-1:0] q_reg;
  logic [QW-1:0] qq_reg;
  logic [IW-1:0] idx_reg;

  logic [OW+M1W-1:0] prod1;
  logic [QW+M2W-1:0] prod2;
  logic [QW+NW-1:0]  prod3;
  logic [QW+NW-1:0]  diff;
  logic [IW+CBW-1:0] grant_full;

  logic [fcfl_pkg::STATUS_W-1:0] out_status;
  logic [OW-1:0]                 out_offset;
  logic [fcfl_pkg::USED_W-1:0]   out_used;

  assign init_cnt_next = (init_cnt == IW'(NUM_CHUNKS - 1)) ? '0 : init_cnt + 1'b1;

  assign prod1 = (OW + M1W)'(offs_reg) * (OW + M1W)'(M1);
  assign prod2 = (QW + M2W)'(q_reg) * (QW + M2W)'(M2);
  assign prod3 = (QW + NW)'(qq_reg) * (QW + NW)'(NUM_CHUNKS);
  assign diff = (QW + NW)'(q_reg) - prod3;
  assign grant_full = (IW + CBW)'(head) * (IW + CBW)'(CHUNK_BYTES);

  assign stat.init_last = (init_cnt == IW'(NUM_CHUNKS - 1));
  assign stat.used_zero = (used == '0);
  assign stat.used_full = (used == UW'(NUM_CHUNKS));
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      link_mem[init_cnt] <= init_cnt_next;
    end else if (cmd.push) begin
      link_mem[idx_reg] <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data <= link_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_reg <= req_in;
      offs_reg <= offs_in;
    end
    if (cmd.div_q) begin
      q_reg <= QW'(prod1 >> S1);
    end
    if (cmd.div_qq) begin
      qq_reg <= QW'(prod2 >> S2);
    end
    if (cmd.div_idx) begin
      idx_reg <= diff[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
      head <= '0;
      used <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.init_wr) begin
        init_cnt <= init_cnt_next;
      end
      if (cmd.pop) begin
        head <= rd_data;
        used <= used + 1'b1;
      end else if (cmd.push) begin
        head <= idx_reg;
        used <= used - 1'b1;
      end
      if (cmd.pop || cmd.push || cmd.reject) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_status <= fcfl_pkg::STATUS_OK;
      out_offset <= OW'(grant_full);
      out_used <= fcfl_pkg::USED_W'(used + 1'b1);
    end else if (cmd.push) begin
      out_status <= fcfl_pkg::STATUS_OK;
      out_offset <= '0;
      out_used <= fcfl_pkg::USED_W'(used - 1'b1);
    end else if (cmd.reject) begin
      out_status <= (req_reg == fcfl_pkg::REQ_FREE) ? fcfl_pkg::STATUS_FREE_NONE
                                                     : fcfl_pkg::STATUS_EXHAUSTED;
      out_offset <= '0;
      out_used <= fcfl_pkg::USED_W'(used);
    end
  end

  assign m_tdata = {{PADW{1'b0}}, out_used, out_offset};
  assign m_tuser = out_status;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(NUM_CHUNKS))
    else $error("Used count exceeds the pool size.");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> (used == $past(used) + 1'b1) && (head == $past(rd_data)))
    else $error("Allocate did not advance the head and count.");

  a_push_head: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> (head == $past(idx_reg)) && (used == $past(used) - 1'b1))
    else $error("Free did not push the chunk as the new head.");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.reject |=> $stable(used) && $stable(head))
    else $error("Rejected request changed the list state.");
`endif

endmodule

`default_nettype wire

/* design/fixed_chunk_free_list_allocator.sv */
// An allocate is answered after a synchronous read of the next-link memory for the head. A free
// is answered after a constant-reciprocal divide (quotient by the chunk size, then by the chunk
// count, then the remainder) maps the offset to a chunk index. A rejected request is answered
// without the divide or a head update. A new beat is accepted only once the previous answer is
// issued; an unread result stalls the answer in place. Reset clears the head and the used count,
// then a pass with s_tready low writes each entry of the link memory.
`default_nettype none

module fixed_chunk_free_list_allocator #(
  parameter int NUM_CHUNKS = fcfl_pkg::NUM_CHUNKS_DEF,
  parameter int CHUNK_BYTES = fcfl_pkg::CHUNK_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // free_offset[9:0], zero pad above.
  input  wire logic [fcfl_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type[0].
  input  wire logic [fcfl_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // alloc_offset[9:0], used_chunks[16:10], zero pad above.
  output logic [fcfl_pkg::M_TDATA_W-1:0]      m_tdata,
  // status[1:0].
  output logic [fcfl_pkg::M_TUSER_W-1:0]      m_tuser
);

  fcfl_pkg::dp_cmd_t  cmd;
  fcfl_pkg::dp_stat_t stat;

  fcfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser[0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcfl_datapath #(
    .NUM_CHUNKS  (NUM_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_in   (s_tuser[0]),
    .offs_in  (s_tdata[fcfl_pkg::OFFSET_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
